// ----- hw/rtl/voxel_neighbour_generator_defines.svh -----
// ---------------------------------------------------------------------------
// Voxel neighbour generator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef VOXEL_NEIGHBOUR_GENERATOR_DEFINES_SVH
`define VOXEL_NEIGHBOUR_GENERATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define VNG_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("voxel neighbour generator: check failed");

// next-cycle implication, clocked on clk, off during reset
`define VNG_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("voxel neighbour generator: check failed");

`endif

// ----- hw/rtl/vng_pkg.sv -----
// ---------------------------------------------------------------------------
// Voxel neighbour generator package
// Shared widths, codes, state type and offset helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vng_pkg;

	localparam int ID_W         = 24;
	localparam int CFG_W        = 9;
	localparam int APB_DW       = 32;
	localparam int PADDR_W      = 4;
	localparam int AXIS_MAX_DEF = 256;
	localparam int DIV_CNT_W    = $clog2(ID_W);
	localparam int STEP_W       = 5;

	// register index, paddr[3:2]
	localparam logic [1:0] REG_COL   = 2'd0;
	localparam logic [1:0] REG_ROW   = 2'd1;
	localparam logic [1:0] REG_LAYER = 2'd2;

	localparam logic [STEP_W-1:0] FACE_LAST = STEP_W'(5);
	localparam logic [STEP_W-1:0] DIAG_LAST = STEP_W'(26);

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NONE = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_COL,
		ST_DIV_ROW,
		ST_CHECK,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		OFS_NEG  = 2'd0,
		OFS_ZERO = 2'd1,
		OFS_POS  = 2'd2
	} ofs_t;

	typedef struct packed {
		ofs_t c;
		ofs_t r;
		ofs_t l;
	} ofs3_t;

	// face order: row-1, row+1, col-1, col+1, layer-1, layer+1
	function automatic ofs3_t face_ofs(logic [2:0] idx);
		ofs3_t o;
		o = '{c: OFS_ZERO, r: OFS_ZERO, l: OFS_ZERO};
		unique case (idx)
			3'd0: o.r = OFS_NEG;
			3'd1: o.r = OFS_POS;
			3'd2: o.c = OFS_NEG;
			3'd3: o.c = OFS_POS;
			3'd4: o.l = OFS_NEG;
			3'd5: o.l = OFS_POS;
			default: o = '{c: OFS_ZERO, r: OFS_ZERO, l: OFS_ZERO};
		endcase
		return o;
	endfunction

	// -1 -> 0 -> +1 -> -1
	function automatic ofs_t ofs_inc(ofs_t o);
		ofs_t n;
		unique case (o)
			OFS_NEG:  n = OFS_ZERO;
			OFS_ZERO: n = OFS_POS;
			default:  n = OFS_NEG;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vng_div.sv -----
// ---------------------------------------------------------------------------
// Voxel neighbour generator divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vng_div #(
	parameter int DVS_W = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [vng_pkg::ID_W-1:0]  dividend,
	input  wire logic [DVS_W-1:0]          divisor,
	output logic                           done,
	output logic [vng_pkg::ID_W-1:0]       quotient,
	output logic [DVS_W-1:0]               remainder
);

	logic [vng_pkg::ID_W-1:0]      quo_q;
	logic [DVS_W-1:0]              rem_q;
	logic [DVS_W-1:0]              dvs_q;
	logic [vng_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          done_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[vng_pkg::ID_W-1]};
		fits    = trial >= {1'b0, dvs_q};
		rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + vng_pkg::DIV_CNT_W'(1);
				if (cnt_q == vng_pkg::DIV_CNT_W'(vng_pkg::ID_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[vng_pkg::ID_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/voxel_neighbour_generator.sv -----
// ---------------------------------------------------------------------------
// Voxel neighbour generator
// Splits a linear cell id into column/row/layer and emits the ids of its
// in-grid face (6) or full (26) neighbours, one per strobe.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+-------------------------------
//  request  | start & !busy                      | cell_id, allow_diagonal
//  result   | strobe (one cycle, no backpressure)| neighbour_id, status, is_last
//  config   | psel & penable & pwrite & pready   | paddr, pwdata / prdata
//
//  Sequencing: a shared restoring divider splits the id, two divides per
//  item (col, then row/layer), so the divider sets most of the latency.
//  busy drops while the last result is on the ports, so the next request
//  can be accepted at the edge that ends it.
//  Reset: arst_n clears control and sets all three sizes to 16.
//  The receiver cannot stall: every strobe is a completed transfer.
//
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_neighbour_generator_defines.svh"

module voxel_neighbour_generator #(
	parameter int AXIS_MAX = vng_pkg::AXIS_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [vng_pkg::ID_W-1:0]      cell_id,
	input  wire logic                          allow_diagonal,
	// result
	output logic                               strobe,
	output logic [vng_pkg::ID_W-1:0]           neighbour_id,
	output logic [1:0]                         status,
	output logic                               is_last,
	// config
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vng_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [vng_pkg::APB_DW-1:0]    pwdata,
	output logic [vng_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);

	// AW holds an effective size (1..AXIS_MAX), CW a coordinate (0..AXIS_MAX-1)
	localparam int AW = $clog2(AXIS_MAX + 1);
	localparam int CW = $clog2(AXIS_MAX);
	localparam int EW = (AW > vng_pkg::CFG_W) ? AW : vng_pkg::CFG_W;
	localparam int PW = 2 * AW;
	// signed width for id + offsets; covers plane + row + 1 above the id
	localparam int SW = ((PW > vng_pkg::ID_W) ? PW : vng_pkg::ID_W) + 2;

	// ---------------- configuration registers ----------------
	logic [vng_pkg::CFG_W-1:0] col_q, row_q, layer_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= vng_pkg::CFG_W'(16);
			row_q   <= vng_pkg::CFG_W'(16);
			layer_q <= vng_pkg::CFG_W'(16);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				vng_pkg::REG_COL:   col_q   <= pwdata[vng_pkg::CFG_W-1:0];
				vng_pkg::REG_ROW:   row_q   <= pwdata[vng_pkg::CFG_W-1:0];
				vng_pkg::REG_LAYER: layer_q <= pwdata[vng_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			vng_pkg::REG_COL:   prdata = vng_pkg::APB_DW'(col_q);
			vng_pkg::REG_ROW:   prdata = vng_pkg::APB_DW'(row_q);
			vng_pkg::REG_LAYER: prdata = vng_pkg::APB_DW'(layer_q);
			default:            prdata = '0;
		endcase
	end

	// zero acts as one, anything above AXIS_MAX as AXIS_MAX
	function automatic logic [AW-1:0] eff_size(logic [vng_pkg::CFG_W-1:0] v);
		logic [EW-1:0] w;
		w = EW'(v);
		if (w == '0)
			return AW'(1);
		else if (w > EW'(AXIS_MAX))
			return AW'(AXIS_MAX);
		else
			return AW'(w);
	endfunction

	logic [AW-1:0] nc, nr, nl;

	assign nc = eff_size(col_q);
	assign nr = eff_size(row_q);
	assign nl = eff_size(layer_q);

	// ---------------- shared divider ----------------
	logic                      div_start;
	logic [vng_pkg::ID_W-1:0]  div_dividend;
	logic [AW-1:0]             div_divisor;
	logic                      div_done;
	logic [vng_pkg::ID_W-1:0]  div_quo;
	logic [AW-1:0]             div_rem;

	vng_div #(
		.DVS_W (AW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ---------------- item state ----------------
	vng_pkg::state_t           state_q, state_nxt;
	logic [vng_pkg::ID_W-1:0]  id_q;
	logic                      diag_q;
	logic [PW-1:0]             plane_q;
	logic [CW-1:0]             c_q, r_q, l_q;
	logic [vng_pkg::STEP_W-1:0] step_q;
	vng_pkg::ofs_t             ofs_c_q, ofs_r_q, ofs_l_q;
	logic                      pend_vld_q;
	logic [vng_pkg::ID_W-1:0]  pend_q;

	logic accept;
	logic id_bad;
	logic last_pos;
	logic pos_ok;

	assign accept = start && !busy;
	assign busy   = (state_q != vng_pkg::ST_IDLE);
	// layer index past the grid means the id was out of range
	assign id_bad = div_quo >= vng_pkg::ID_W'(nl);

	// ---------------- neighbour scan datapath ----------------
	function automatic logic axis_ok(vng_pkg::ofs_t o, logic [CW-1:0] x, logic [AW-1:0] n);
		logic ok;
		unique case (o)
			vng_pkg::OFS_NEG:  ok = (x != '0);
			vng_pkg::OFS_ZERO: ok = 1'b1;
			vng_pkg::OFS_POS:  ok = (AW'(x) + AW'(1)) < n;
			default:           ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic signed [SW-1:0] term(vng_pkg::ofs_t o, logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		unique case (o)
			vng_pkg::OFS_NEG: t = -v;
			vng_pkg::OFS_POS: t = v;
			default:          t = '0;
		endcase
		return t;
	endfunction

	vng_pkg::ofs3_t        cur;
	logic signed [SW-1:0]  id_s, pl_s, nc_s, one_s, sum;
	logic                  centre;

	always_comb begin
		if (diag_q)
			cur = '{c: ofs_c_q, r: ofs_r_q, l: ofs_l_q};
		else
			cur = vng_pkg::face_ofs(step_q[2:0]);
		centre = (cur.c == vng_pkg::OFS_ZERO) && (cur.r == vng_pkg::OFS_ZERO) &&
			(cur.l == vng_pkg::OFS_ZERO);
		pos_ok = axis_ok(cur.c, c_q, nc) && axis_ok(cur.r, r_q, nr) &&
			axis_ok(cur.l, l_q, nl) && !centre;
		last_pos = diag_q ? (step_q == vng_pkg::DIAG_LAST) : (step_q == vng_pkg::FACE_LAST);
		id_s  = $signed(SW'(id_q));
		pl_s  = $signed(SW'(plane_q));
		nc_s  = $signed(SW'(nc));
		one_s = $signed(SW'(1));
		// neighbour id = id + dl*plane + dr*cols + dc, kept to 24 bits
		sum = id_s + term(cur.l, pl_s) + term(cur.r, nc_s) + term(cur.c, one_s);
	end

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			vng_pkg::ST_IDLE:    if (start) state_nxt = vng_pkg::ST_DIV_COL;
			vng_pkg::ST_DIV_COL: if (div_done) state_nxt = vng_pkg::ST_DIV_ROW;
			vng_pkg::ST_DIV_ROW: if (div_done) state_nxt = vng_pkg::ST_CHECK;
			vng_pkg::ST_CHECK:   state_nxt = id_bad ? vng_pkg::ST_IDLE : vng_pkg::ST_SCAN;
			vng_pkg::ST_SCAN:    if (last_pos) state_nxt = vng_pkg::ST_FLUSH;
			vng_pkg::ST_FLUSH:   state_nxt = vng_pkg::ST_IDLE;
			default:             state_nxt = vng_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	logic                     cap_c, cap_rl, scan_run, pend_load;
	logic                     emit, emit_last;
	logic [vng_pkg::ID_W-1:0] emit_id;
	vng_pkg::status_t         emit_st;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = cell_id;
		div_divisor  = nc;
		cap_c        = 1'b0;
		cap_rl       = 1'b0;
		scan_run     = 1'b0;
		pend_load    = 1'b0;
		emit         = 1'b0;
		emit_last    = 1'b0;
		emit_id      = '0;
		emit_st      = vng_pkg::STATUS_OK;
		unique case (state_q)
			vng_pkg::ST_IDLE: begin
				div_start = start;
			end
			vng_pkg::ST_DIV_COL: begin
				// column = id mod cols; quotient goes on for row and layer
				div_dividend = div_quo;
				div_divisor  = nr;
				div_start    = div_done;
				cap_c        = div_done;
			end
			vng_pkg::ST_DIV_ROW: ;
			vng_pkg::ST_CHECK: begin
				cap_rl = 1'b1;
				if (id_bad) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					emit_st   = vng_pkg::STATUS_BAD;
				end
			end
			vng_pkg::ST_SCAN: begin
				// hold one found neighbour back so the final one gets is_last
				scan_run  = 1'b1;
				pend_load = pos_ok;
				emit      = pos_ok && pend_vld_q;
				emit_id   = pend_q;
			end
			vng_pkg::ST_FLUSH: begin
				emit      = 1'b1;
				emit_last = 1'b1;
				emit_id   = pend_vld_q ? pend_q : '0;
				emit_st   = pend_vld_q ? vng_pkg::STATUS_OK : vng_pkg::STATUS_NONE;
			end
			default: ;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vng_pkg::ST_IDLE;
			pend_vld_q <= 1'b0;
			step_q     <= '0;
			ofs_c_q    <= vng_pkg::OFS_NEG;
			ofs_r_q    <= vng_pkg::OFS_NEG;
			ofs_l_q    <= vng_pkg::OFS_NEG;
		end else begin
			state_q <= state_nxt;
			if (cap_rl) begin
				pend_vld_q <= 1'b0;
				step_q     <= '0;
				ofs_c_q    <= vng_pkg::OFS_NEG;
				ofs_r_q    <= vng_pkg::OFS_NEG;
				ofs_l_q    <= vng_pkg::OFS_NEG;
			end else if (scan_run) begin
				if (pend_load)
					pend_vld_q <= 1'b1;
				step_q  <= step_q + vng_pkg::STEP_W'(1);
				// layer innermost, then row, column outermost
				ofs_l_q <= vng_pkg::ofs_inc(ofs_l_q);
				if (ofs_l_q == vng_pkg::OFS_POS) begin
					ofs_r_q <= vng_pkg::ofs_inc(ofs_r_q);
					if (ofs_r_q == vng_pkg::OFS_POS)
						ofs_c_q <= vng_pkg::ofs_inc(ofs_c_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= cell_id;
			diag_q  <= allow_diagonal;
			plane_q <= PW'(nc) * PW'(nr);
		end
		if (cap_c)
			c_q <= div_rem[CW-1:0];
		if (cap_rl) begin
			r_q <= div_rem[CW-1:0];
			l_q <= div_quo[CW-1:0];
		end
		if (pend_load)
			pend_q <= sum[vng_pkg::ID_W-1:0];
	end

	// ---------------- result register ----------------
	logic                     strobe_q;
	logic [vng_pkg::ID_W-1:0] nid_q;
	vng_pkg::status_t         status_q;
	logic                     last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			nid_q    <= emit_id;
			status_q <= emit_st;
			last_q   <= emit_last;
		end
	end

	assign strobe       = strobe_q;
	assign neighbour_id = nid_q;
	assign status       = status_q;
	assign is_last      = last_q;

	// ---------------- assertions ----------------
	`VNG_ASSERT_NOW(a_err_is_last, strobe && (status != vng_pkg::STATUS_OK), is_last)
	`VNG_ASSERT_NOW(a_err_zero_id, strobe && (status != vng_pkg::STATUS_OK), neighbour_id == '0)
	`VNG_ASSERT_NOW(a_mid_result_busy, strobe && !is_last, busy)
	`VNG_ASSERT_NEXT(a_gap_after_last, strobe && is_last, !strobe)

endmodule

`default_nettype wire

// ----- verif/vng_result_checker.sv -----
// ---------------------------------------------------------------------------
// Voxel neighbour generator result checker
// Tracks the size registers, checks their readback, predicts the neighbour
// list of every accepted cell and compares each strobed result against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vng_result_checker #(
	parameter int AXIS_MAX = vng_pkg::AXIS_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [vng_pkg::ID_W-1:0]      cell_id,
	input  logic                          allow_diagonal,
	input  logic                          strobe,
	input  logic [vng_pkg::ID_W-1:0]      neighbour_id,
	input  logic [1:0]                    status,
	input  logic                          is_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vng_pkg::PADDR_W-1:0]   paddr,
	input  logic [vng_pkg::APB_DW-1:0]    pwdata,
	input  logic [vng_pkg::APB_DW-1:0]    prdata,
	input  logic                          pready,
	output int                            mismatches,
	output int                            outstanding
);

	import vng_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0] id;
		status_t         st;
		logic            last;
	} nbr_t;

	logic [CFG_W-1:0] col_size;
	logic [CFG_W-1:0] row_size;
	logic [CFG_W-1:0] layer_size;

	nbr_t expected_nbrs[$];
	int   mismatch_total;

	// 0 acts as 1, anything above AXIS_MAX is clamped
	function automatic longint axis_span(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		else if (v > AXIS_MAX)
			return AXIS_MAX;
		else
			return longint'(v);
	endfunction

	function automatic bit in_grid(input longint a, input longint b, input longint h,
			input longint nc, input longint nr, input longint nl);
		return a >= 0 && a < nc && b >= 0 && b < nr && h >= 0 && h < nl;
	endfunction

	// append one expected result at the tail
	function automatic void queue_expected(input nbr_t x);
		expected_nbrs.insert(expected_nbrs.size(), x);
	endfunction

	function automatic void predict_neighbours(input logic [ID_W-1:0] id, input logic diag);
		nbr_t   found[26];
		nbr_t   one;
		longint nc, nr, nl, plane, cid, c, r, l, a, b, h;
		int     n, t;
		nc    = axis_span(col_size);
		nr    = axis_span(row_size);
		nl    = axis_span(layer_size);
		plane = nc * nr;
		cid   = id;
		n     = 0;
		one.id   = '0;
		one.last = 1'b1;
		if (cid >= plane * nl) begin
			one.st = STATUS_BAD;
			queue_expected(one);
		end else begin
			c = cid % nc;
			r = (cid / nc) % nr;
			l = cid / plane;
			if (!diag) begin
				// face order: row-1, row+1, col-1, col+1, layer-1, layer+1
				for (t = 0; t < 6; t++) begin
					a = c;
					b = r;
					h = l;
					case (t)
						0: b = r - 1;
						1: b = r + 1;
						2: a = c - 1;
						3: a = c + 1;
						4: h = l - 1;
						default: h = l + 1;
					endcase
					if (in_grid(a, b, h, nc, nr, nl)) begin
						found[n].id = h * plane + b * nc + a;
						found[n].st = STATUS_OK;
						n++;
					end
				end
			end else begin
				// column outermost, layer innermost, centre skipped
				for (a = c - 1; a <= c + 1; a++)
					for (b = r - 1; b <= r + 1; b++)
						for (h = l - 1; h <= l + 1; h++)
							if (in_grid(a, b, h, nc, nr, nl) &&
									!(a == c && b == r && h == l)) begin
								found[n].id = h * plane + b * nc + a;
								found[n].st = STATUS_OK;
								n++;
							end
			end
			if (n == 0) begin
				one.st = STATUS_NONE;
				queue_expected(one);
			end else begin
				for (t = 0; t < n; t++) begin
					found[t].last = (t == n - 1);
					queue_expected(found[t]);
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_total++;
		$display("%0t ns: MISMATCH %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	function automatic logic [CFG_W-1:0] size_at(input logic [1:0] idx);
		case (idx)
			REG_COL: return col_size;
			REG_ROW: return row_size;
			default: return layer_size;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nbr_t want;
		if (!arst_n) begin
			col_size       = 9'd16;
			row_size       = 9'd16;
			layer_size     = 9'd16;
			mismatch_total = 0;
			expected_nbrs.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_COL:   col_size   = pwdata[CFG_W-1:0];
					REG_ROW:   row_size   = pwdata[CFG_W-1:0];
					REG_LAYER: layer_size = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			// register readback
			if (psel && penable && !pwrite && pready && paddr[3:2] != 2'd3) begin
				if (prdata !== {{(APB_DW-CFG_W){1'b0}}, size_at(paddr[3:2])})
					report_mismatch("prdata", prdata,
						{{(APB_DW-CFG_W){1'b0}}, size_at(paddr[3:2])});
			end
			// result transfer: retire the oldest expectation
			if (strobe !== 1'b0) begin
				if (expected_nbrs.size() == 0) begin
					report_mismatch("unexpected result, neighbour_id", neighbour_id, 0);
				end else begin
					want = expected_nbrs.pop_front();
					if (neighbour_id !== want.id)
						report_mismatch("neighbour_id", neighbour_id, want.id);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (is_last !== want.last)
						report_mismatch("is_last", is_last, want.last);
				end
			end
			// request transfer
			if (start && !busy)
				predict_neighbours(cell_id, allow_diagonal);
			mismatches  <= mismatch_total;
			outstanding <= expected_nbrs.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// Voxel neighbour generator testbench
// Directed corner, edge, out-of-grid and degenerate-grid cells, then random
// grid sizes with mostly in-grid cells biased to the grid borders. A checker
// beside the block predicts every neighbour list and compares the strobes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import vng_pkg::*;

	// generous: ~180 cells plus idles and register access
	localparam int CYCLE_LIMIT = 200000;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                start          = 1'b0;
	logic [ID_W-1:0]     cell_id        = '0;
	logic                allow_diagonal = 1'b0;
	logic                psel           = 1'b0;
	logic                penable        = 1'b0;
	logic                pwrite         = 1'b0;
	logic [PADDR_W-1:0]  paddr          = '0;
	logic [APB_DW-1:0]   pwdata         = '0;

	logic                busy;
	logic                strobe;
	logic [ID_W-1:0]     neighbour_id;
	logic [1:0]          status;
	logic                is_last;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int mismatches;
	int outstanding;
	int cycle_count = 0;

	// request side idles at random unless this is cleared
	bit idle_on = 1'b1;

	// effective grid size as currently programmed, for choosing cells
	int grid_cols = 16;
	int grid_rows = 16;
	int grid_layers = 16;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	voxel_neighbour_generator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cell_id        (cell_id),
		.allow_diagonal (allow_diagonal),
		.strobe         (strobe),
		.neighbour_id   (neighbour_id),
		.status         (status),
		.is_last        (is_last),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	vng_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cell_id        (cell_id),
		.allow_diagonal (allow_diagonal),
		.strobe         (strobe),
		.neighbour_id   (neighbour_id),
		.status         (status),
		.is_last        (is_last),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// All tasks below are entered right after a rising edge and return right
	// after one, so every drive lands as one nonblocking update per edge.

	// Present one cell. start is dropped on random cycles while waiting, so
	// gaps land both inside the busy window and right as busy falls. start is
	// left high on return so the next cell can follow back to back.
	task automatic issue_cell(input logic [ID_W-1:0] id, input logic diag);
		logic idle;
		cell_id        <= id;
		allow_diagonal <= diag;
		do begin
			idle = idle_on && ($urandom_range(0, 99) < 27);
			start <= !idle;
			@(posedge clk);
		end while (!(start && !busy));
	endtask

	// Block idle: every expected result has come back and busy is low.
	task automatic drain_results;
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Setup + access phase; upper data bits are random, only [8:0] is kept.
	task automatic csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		logic [APB_DW-1:0] word;
		word           = $urandom();
		word[CFG_W-1:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// readback data is compared by the checker at the access edge
	task automatic csr_read(input logic [1:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int axis_span(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		else if (v > AXIS_MAX_DEF)
			return AXIS_MAX_DEF;
		else
			return int'(v);
	endfunction

	// Reprogram the grid once the block is idle, then read all three back.
	task automatic load_grid(input logic [CFG_W-1:0] cs, input logic [CFG_W-1:0] rs,
			input logic [CFG_W-1:0] ls);
		drain_results;
		csr_write(REG_COL, cs);
		csr_write(REG_ROW, rs);
		csr_write(REG_LAYER, ls);
		csr_read(REG_COL);
		csr_read(REG_ROW);
		csr_read(REG_LAYER);
		grid_cols   = axis_span(cs);
		grid_rows   = axis_span(rs);
		grid_layers = axis_span(ls);
	endtask

	// Size mix: zero, oversized, full, single, and mostly small axes.
	function automatic logic [CFG_W-1:0] rand_axis();
		int k;
		k = $urandom_range(0, 99);
		if (k < 12)
			return '0;
		else if (k < 24)
			return $urandom_range(257, 511);
		else if (k < 34)
			return 9'd256;
		else if (k < 44)
			return 9'd1;
		else
			return $urandom_range(2, 12);
	endfunction

	// borders are where the neighbour lists get clipped
	function automatic longint coord_pick(input int n);
		int k;
		k = $urandom_range(0, 99);
		if (k < 30)
			return 0;
		else if (k < 60)
			return n - 1;
		else
			return $urandom_range(0, n - 1);
	endfunction

	// Mostly in-grid cells; some just around the last id, some full 24-bit noise.
	function automatic logic [ID_W-1:0] pick_cell();
		longint total, v;
		int     k;
		total = longint'(grid_cols) * grid_rows * grid_layers;
		k     = $urandom_range(0, 99);
		if (k < 10)
			v = $urandom_range(0, 24'hFFFFFF);
		else if (k < 18)
			v = total - 1 + $urandom_range(0, 2);
		else
			v = coord_pick(grid_layers) * grid_cols * grid_rows +
				coord_pick(grid_rows) * grid_cols + coord_pick(grid_cols);
		return v[ID_W-1:0];
	endfunction

	task automatic random_phase(input int n_cells);
		int i;
		load_grid(rand_axis(), rand_axis(), rand_axis());
		for (i = 0; i < n_cells; i++) begin
			// occasional long pause so a new cell shows up at any point
			if (idle_on && $urandom_range(0, 99) < 8) begin
				start <= 1'b0;
				repeat ($urandom_range(5, 90)) @(posedge clk);
			end
			issue_cell(pick_cell(), $urandom_range(0, 1));
		end
	endtask

	initial begin
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes read back as 16
		csr_read(REG_COL);
		csr_read(REG_ROW);
		csr_read(REG_LAYER);

		// default 16x16x16: corners, centre, an edge cell, first bad id, all-ones id
		issue_cell(24'd0, 1'b0);
		issue_cell(24'd0, 1'b1);
		issue_cell(24'd4095, 1'b0);
		issue_cell(24'd4095, 1'b1);
		issue_cell(24'd1365, 1'b0);
		issue_cell(24'd1365, 1'b1);
		issue_cell(24'd3952, 1'b1);
		issue_cell(24'd4096, 1'b0);
		issue_cell(24'hFFFFFF, 1'b1);

		// single cell grid: no neighbours in either mode, id 1 already outside
		load_grid(9'd1, 9'd1, 9'd1);
		issue_cell(24'd0, 1'b0);
		issue_cell(24'd0, 1'b1);
		issue_cell(24'd1, 1'b0);

		// zero sizes behave as one
		load_grid(9'd0, 9'd0, 9'd0);
		issue_cell(24'd0, 1'b1);
		issue_cell(24'd5, 1'b0);

		// oversized sizes clamp to 256 each: the grid spans the full id range
		load_grid(9'd511, 9'd300, 9'd257);
		issue_cell(24'hFFFFFF, 1'b1);
		issue_cell(24'd0, 1'b0);
		issue_cell(24'd0, 1'b1);
		issue_cell(24'h808080, 1'b1);

		// a single line along x, with zero layers
		load_grid(9'd256, 9'd1, 9'd0);
		issue_cell(24'd0, 1'b1);
		issue_cell(24'd255, 1'b0);
		issue_cell(24'd128, 1'b1);
		issue_cell(24'd256, 1'b0);

		// random grids; one phase runs with no request idling at all
		for (p = 0; p < 6; p++) begin
			idle_on = (p != 3);
			random_phase(26);
		end

		drain_results;
		// quiet window to catch stray strobes
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/vng_pkg.sv
hw/rtl/vng_div.sv
hw/rtl/voxel_neighbour_generator.sv
verif/vng_result_checker.sv
verif/tb.sv
